### rtl/core/pomh_pkg.sv
// ----------------------------------------------------------------------------
// pomh_pkg
// shared types and constants of the path oblivious min-heap
// ----------------------------------------------------------------------------
package pomh_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int RAND_W    = 10;
  localparam int COUNT_W   = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic [1:0] OP_FIND     = 2'd0;
  localparam logic [1:0] OP_PAD_FIND = 2'd1;
  localparam logic [1:0] OP_INSERT   = 2'd2;
  localparam logic [1:0] OP_EXTRACT  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [RAND_W-1:0] rand_a;
    logic [RAND_W-1:0] rand_b;
    logic [RAND_W-1:0] rand_c;
  } pomh_in_t;

  typedef struct packed {
    logic               min_valid;
    logic [KEY_W-1:0]   min_key;
    logic [VAL_W-1:0]   min_value;
    logic               stash_overflow;
    logic [COUNT_W-1:0] element_count;
  } pomh_out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr;
    logic latch;
    logic root_cap;
    logic ins;
    logic path_start;
    logic path_sel;
    logic rp_slot;
    logic ev_start;
    logic ev_lvl;
    logic ev_scan;
    logic ev_wr;
    logic ev_sib;
    logic cmp_start;
    logic cmp_step;
    logic out_load;
  } pomh_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       slot_last;
    logic       node_root;
    logic       scan_done;
    logic       cmp_done;
    logic       out_busy;
  } pomh_sts_t;

endpackage

### rtl/core/path_oblivious_min_heap_top.sv
// ----------------------------------------------------------------------------
// path_oblivious_min_heap_top
// path oblivious min-heap with bucket tree, subtree minima and stash
// ----------------------------------------------------------------------------
// The heap takes one item at a time (find-min, padded find-min, insert,
// extract-min) and returns one result item per input item. After reset it
// runs a clearing pass over the bucket and minimum memories, during which
// no item is accepted. An item first reads the root; a plain find-min then
// finishes, while every other item goes on to two paths. For each path it
// starts the path read, reads the path into the stash bucket by bucket and
// level by level, starts the eviction, evicts level by level with a scan of
// the stash, and then compacts the stash; a tree has log2(CAPACITY)+1 levels.
// The stash scan of each level dominates the run time of an item, which so
// grows with stash fill. The result sits in an output register, so the next
// item may be accepted while the last result is still stalled.
// ----------------------------------------------------------------------------
module path_oblivious_min_heap_top
  import pomh_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int BUCKET_SIZE = 4,
  parameter int STASH_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // input item channel
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pomh_in_t  in_data_i,
  // result item channel
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pomh_out_t out_data_o
);

  // controller and datapath talk only through these two groups
  pomh_cmd_t cmd;
  pomh_sts_t sts;

  pomh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // bucket, minimum and stash memories with their walk counters
  pomh_dp #(
    .CAPACITY    (CAPACITY),
    .BUCKET_SIZE (BUCKET_SIZE),
    .STASH_DEPTH (STASH_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/pomh_dp.sv
// ----------------------------------------------------------------------------
// pomh_dp
// bucket tree, subtree minima, stash and the counters that walk them
// ----------------------------------------------------------------------------
module pomh_dp
  import pomh_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int BUCKET_SIZE = 4,
  parameter int STASH_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pomh_in_t  in_data_i,
  input  pomh_cmd_t cmd_i,
  output pomh_sts_t sts_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pomh_out_t out_data_o
);

  localparam int NW    = $clog2(2 * CAPACITY);
  localparam int NODES = 2 * CAPACITY - 1;
  localparam int SW    = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
  localparam int NCW   = $clog2(BUCKET_SIZE + 1);
  localparam int AW    = $clog2(STASH_DEPTH);
  localparam int CW    = $clog2(STASH_DEPTH + 1);
  localparam int LVW   = $clog2(NW + 1);
  localparam logic [NW-1:0]  LEAF_BASE = NW'(CAPACITY - 1);
  localparam logic [NW-1:0]  HALF      = NW'(CAPACITY / 2);
  localparam logic [NW-1:0]  RMASK     = NW'(CAPACITY - 1);
  localparam logic [CW-1:0]  DEPTH_C   = CW'(STASH_DEPTH);
  localparam logic [NCW-1:0] BS_C      = NCW'(BUCKET_SIZE);

  typedef struct packed {
    logic [NW-1:0]    leaf;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } blk_t;
  typedef blk_t [BUCKET_SIZE-1:0] row_t;

  // memories
  row_t bkt_mem   [NODES];
  blk_t min_mem   [NODES];
  blk_t stash_mem [STASH_DEPTH];
  row_t bkt_rd_q;
  blk_t min_rd_q;
  blk_t stash_rd_q;

  pomh_in_t         in_q;
  blk_t             rmin_q, m_q, c_q;
  row_t             ev_row_q;
  logic [NW-1:0]    leaf_a_q, leaf_b_q, cur_leaf_q, node_q;
  logic             skip_q, skip_cur_q, gone_q;
  logic [LVW-1:0]   lvl_q;
  logic [SW-1:0]    s_q;
  logic [NCW-1:0]   n_q;
  logic [CW-1:0]    j_q, w_q, cnt_q;
  logic             rv_q;
  logic [AW-1:0]    rj_q;
  logic [STASH_DEPTH-1:0] taken_q;
  logic [COUNT_W-1:0]     heap_q;
  logic             drop_q;
  logic             res_valid_q;
  logic [KEY_W-1:0] res_key_q;
  logic [VAL_W-1:0] res_val_q;
  logic [NW-1:0]    clr_q;
  logic             out_valid_q;
  pomh_out_t        out_q;

  // random numbers reduced to the tree width
  logic [NW+RAND_W-1:0] ra_w, rb_w, rc_w;
  logic [NW-1:0]        ra, rb, rc;
  assign ra_w = {{NW{1'b0}}, in_q.rand_a};
  assign rb_w = {{NW{1'b0}}, in_q.rand_b};
  assign rc_w = {{NW{1'b0}}, in_q.rand_c};
  assign ra   = ra_w[NW-1:0] & RMASK;
  assign rb   = rb_w[NW-1:0] & RMASK;
  assign rc   = rc_w[NW-1:0] & RMASK;

  function automatic logic better(blk_t cand, blk_t cur);
    better = (cand.leaf != '0) && ((cur.leaf == '0) || (cand.key < cur.key));
  endfunction

  logic [NW-1:0] idx, sib, a_pos, ext_leaf;
  assign idx      = node_q - NW'(1);
  assign sib      = idx[0] ? idx + NW'(1) : idx - NW'(1);
  assign a_pos    = LEAF_BASE + stash_rd_q.leaf;
  assign ext_leaf = (((HALF & (min_rd_q.leaf - NW'(1))) ^ HALF) | (rb >> 1)) + NW'(1);

  // root capture: result and the two path leaves of the item
  logic          root_hit, ext_hit;
  logic [NW-1:0] pa_d, pb_d;
  assign root_hit = (in_q.op != OP_INSERT) && (min_rd_q.leaf != '0);
  assign ext_hit  = (in_q.op == OP_EXTRACT) && (min_rd_q.leaf != '0);
  always_comb begin
    pa_d = (ra >> 1) + NW'(1);
    pb_d = ((rb >> 1) | HALF) + NW'(1);
    if (in_q.op == OP_INSERT) begin
      pa_d = (rb >> 1) + NW'(1);
      pb_d = ((rc >> 1) | HALF) + NW'(1);
    end else if (ext_hit) begin
      pa_d = min_rd_q.leaf;
      pb_d = ext_leaf;
    end
  end

  // stash push from insert or path read
  blk_t cur_slot;
  logic skip_hit, push_en, push_ok;
  blk_t push_blk;
  assign cur_slot = bkt_rd_q[s_q];
  assign skip_hit = skip_cur_q && !gone_q && (cur_slot.leaf == cur_leaf_q) &&
                    (cur_slot.key == rmin_q.key) && (cur_slot.value == rmin_q.value);
  always_comb begin
    push_en  = 1'b0;
    push_blk = cur_slot;
    if (cmd_i.ins) begin
      push_en  = 1'b1;
      push_blk = '{leaf: ra + NW'(1), key: in_q.key, value: in_q.value};
    end else if (cmd_i.rp_slot) begin
      push_en = !skip_hit && (cur_slot.leaf != '0);
    end
  end
  assign push_ok = push_en && (cnt_q < DEPTH_C);

  // stash scan for eviction and compaction
  logic more, issue, ev_hit, cmp_keep;
  assign more     = (j_q < cnt_q) && (cmd_i.cmp_step || (n_q < BS_C));
  assign issue    = (cmd_i.ev_scan || cmd_i.cmp_step) && more;
  assign ev_hit   = cmd_i.ev_scan && rv_q && (n_q < BS_C) && !taken_q[rj_q] &&
                    ((a_pos >> lvl_q) == node_q);
  assign cmp_keep = cmd_i.cmp_step && rv_q && !taken_q[rj_q];

  // memory ports
  always_ff @(posedge clk_i) begin
    bkt_rd_q   <= bkt_mem[idx];
    min_rd_q   <= min_mem[cmd_i.ev_wr ? sib : '0];
    stash_rd_q <= stash_mem[j_q[AW-1:0]];
    if (cmd_i.clr) begin
      bkt_mem[clr_q] <= '0;
      min_mem[clr_q] <= '0;
    end else if (cmd_i.ev_wr) begin
      bkt_mem[idx] <= ev_row_q;
      min_mem[idx] <= m_q;
    end
    if (push_ok) begin
      stash_mem[cnt_q[AW-1:0]] <= push_blk;
    end else if (cmp_keep) begin
      stash_mem[w_q[AW-1:0]] <= stash_rd_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      cnt_q       <= '0;
      heap_q      <= '0;
      drop_q      <= 1'b0;
      gone_q      <= 1'b0;
      s_q         <= '0;
      n_q         <= '0;
      j_q         <= '0;
      w_q         <= '0;
      rv_q        <= 1'b0;
      rj_q        <= '0;
      lvl_q       <= '0;
      node_q      <= NW'(1);
      taken_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + NW'(1);
      if (cmd_i.latch) drop_q <= 1'b0;
      else if (push_en && !push_ok) drop_q <= 1'b1;
      if (push_ok) cnt_q <= cnt_q + CW'(1);
      if (cmd_i.ins && push_ok && (heap_q < COUNT_MAX)) heap_q <= heap_q + COUNT_W'(1);
      if (cmd_i.root_cap && ext_hit && (heap_q != '0)) begin
        heap_q <= heap_q - COUNT_W'(1);
      end
      if (cmd_i.path_start) begin
        node_q <= LEAF_BASE + (cmd_i.path_sel ? leaf_b_q : leaf_a_q);
        gone_q <= 1'b0;
        s_q    <= '0;
      end
      if (cmd_i.rp_slot) begin
        if (skip_hit) gone_q <= 1'b1;
        if (s_q == SW'(BUCKET_SIZE - 1)) begin
          s_q    <= '0;
          node_q <= node_q >> 1;
        end else begin
          s_q <= s_q + SW'(1);
        end
      end
      if (cmd_i.ev_start) begin
        taken_q <= '0;
        node_q  <= LEAF_BASE + cur_leaf_q;
        lvl_q   <= '0;
      end
      if (cmd_i.ev_lvl || cmd_i.cmp_start) begin
        n_q  <= '0;
        j_q  <= '0;
        w_q  <= '0;
        rv_q <= 1'b0;
      end
      if (cmd_i.ev_scan || cmd_i.cmp_step) begin
        rv_q <= issue;
        rj_q <= j_q[AW-1:0];
        if (issue) j_q <= j_q + CW'(1);
      end
      if (ev_hit) begin
        taken_q[rj_q] <= 1'b1;
        n_q           <= n_q + NCW'(1);
      end
      if (cmp_keep) w_q <= w_q + CW'(1);
      if (cmd_i.cmp_step && !rv_q && !more) cnt_q <= w_q;
      if (cmd_i.ev_sib) begin
        node_q <= node_q >> 1;
        lvl_q  <= lvl_q + LVW'(1);
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) in_q <= in_data_i;
    if (cmd_i.root_cap) begin
      rmin_q      <= min_rd_q;
      skip_q      <= ext_hit;
      res_valid_q <= root_hit;
      res_key_q   <= root_hit ? min_rd_q.key : '0;
      res_val_q   <= root_hit ? min_rd_q.value : '0;
      leaf_a_q    <= pa_d;
      leaf_b_q    <= pb_d;
    end
    if (cmd_i.path_start) begin
      cur_leaf_q <= cmd_i.path_sel ? leaf_b_q : leaf_a_q;
      skip_cur_q <= skip_q && !cmd_i.path_sel;
    end
    if (cmd_i.ev_start) c_q <= '0;
    if (cmd_i.ev_lvl) begin
      ev_row_q <= '0;
      m_q      <= c_q;
    end
    if (ev_hit) begin
      ev_row_q[n_q[SW-1:0]] <= stash_rd_q;
      if (better(stash_rd_q, m_q)) m_q <= stash_rd_q;
    end
    if (cmd_i.ev_sib) begin
      if ((node_q != NW'(1)) && better(min_rd_q, m_q)) c_q <= min_rd_q;
      else c_q <= m_q;
    end
    if (cmd_i.out_load) begin
      out_q <= '{min_valid: res_valid_q, min_key: res_key_q, min_value: res_val_q,
                 stash_overflow: drop_q, element_count: heap_q};
    end
  end

  assign sts_o.clr_last  = (clr_q == NW'(NODES - 1));
  assign sts_o.op        = in_q.op;
  assign sts_o.slot_last = (s_q == SW'(BUCKET_SIZE - 1));
  assign sts_o.node_root = (node_q == NW'(1));
  assign sts_o.scan_done = !rv_q && !((j_q < cnt_q) && (n_q < BS_C));
  assign sts_o.cmp_done  = !rv_q && !(j_q < cnt_q);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/pomh_ctrl.sv
// ----------------------------------------------------------------------------
// pomh_ctrl
// operation sequencer: clear pass, path reads, evictions, compaction
// ----------------------------------------------------------------------------
module pomh_ctrl
  import pomh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pomh_sts_t sts_i,
  output pomh_cmd_t cmd_o
);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ROOT     = 4'd2;
  localparam logic [3:0] S_INS      = 4'd3;
  localparam logic [3:0] S_PSTART   = 4'd4;
  localparam logic [3:0] S_RPRD     = 4'd5;
  localparam logic [3:0] S_RPSLOT   = 4'd6;
  localparam logic [3:0] S_EVSTART  = 4'd7;
  localparam logic [3:0] S_EVLVL    = 4'd8;
  localparam logic [3:0] S_EVSCAN   = 4'd9;
  localparam logic [3:0] S_EVWR     = 4'd10;
  localparam logic [3:0] S_EVSIB    = 4'd11;
  localparam logic [3:0] S_CMPSTART = 4'd12;
  localparam logic [3:0] S_CMP      = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  logic [3:0] state_q, state_d;
  logic       second_q, second_d;

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    cmd_o    = '0;
    cmd_o.path_sel = second_q;
    case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          second_d    = 1'b0;
          state_d     = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.root_cap = 1'b1;
        case (sts_i.op)
          OP_FIND:   state_d = S_DONE;
          OP_INSERT: state_d = S_INS;
          default:   state_d = S_PSTART;
        endcase
      end
      S_INS: begin
        cmd_o.ins = 1'b1;
        state_d   = S_PSTART;
      end
      S_PSTART: begin
        cmd_o.path_start = 1'b1;
        state_d          = S_RPRD;
      end
      S_RPRD: begin
        state_d = S_RPSLOT;
      end
      S_RPSLOT: begin
        cmd_o.rp_slot = 1'b1;
        if (sts_i.slot_last) state_d = sts_i.node_root ? S_EVSTART : S_RPRD;
      end
      S_EVSTART: begin
        cmd_o.ev_start = 1'b1;
        state_d        = S_EVLVL;
      end
      S_EVLVL: begin
        cmd_o.ev_lvl = 1'b1;
        state_d      = S_EVSCAN;
      end
      S_EVSCAN: begin
        cmd_o.ev_scan = 1'b1;
        if (sts_i.scan_done) state_d = S_EVWR;
      end
      S_EVWR: begin
        cmd_o.ev_wr = 1'b1;
        state_d     = S_EVSIB;
      end
      S_EVSIB: begin
        cmd_o.ev_sib = 1'b1;
        state_d      = sts_i.node_root ? S_CMPSTART : S_EVLVL;
      end
      S_CMPSTART: begin
        cmd_o.cmp_start = 1'b1;
        state_d         = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp_step = 1'b1;
        if (sts_i.cmp_done) begin
          if (!second_q) begin
            second_d = 1'b1;
            state_d  = S_PSTART;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // an accepted item always goes to the root read next
  a_accept_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_ROOT))
    else $error("accepted item did not start at the root");

  // the result register is never overwritten while it is held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("result loaded over a stalled result");

  // the clearing pass runs once after reset
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLR) |=> (state_q != S_CLR))
    else $error("clearing pass re-entered");

endmodule

### tb/sv/path_oblivious_min_heap_top_test.sv
// ----------------------------------------------------------------------------
// path_oblivious_min_heap_top_test
// self-checking bench for the path oblivious min-heap
// ----------------------------------------------------------------------------
// A behavioral copy of the heap (bucket tree, subtree minima, ordered stash)
// predicts the result of every accepted item. Results are checked field by
// field in order. Stimulus is a directed opening, then random runs of mostly
// inserts and extracts with varied handshake idling, and one long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------

class heap_scoreboard;
  localparam int CAP   = 1024;
  localparam int BKT   = 4;
  localparam int STASH = 64;
  localparam int NODES = 2 * CAP - 1;

  bit [10:0] slot_leaf [NODES*BKT];
  bit [31:0] slot_key  [NODES*BKT];
  bit [31:0] slot_val  [NODES*BKT];
  bit [10:0] min_leaf  [NODES];
  bit [31:0] min_key   [NODES];
  bit [31:0] min_val   [NODES];
  bit [10:0] st_leaf   [STASH];
  bit [31:0] st_key    [STASH];
  bit [31:0] st_val    [STASH];
  int unsigned st_cnt;
  int unsigned heap_cnt;
  bit dropped;
  pomh_pkg::pomh_out_t pending_results[$];
  int errors;

  function new();
    for (int i = 0; i < NODES*BKT; i++) begin
      slot_leaf[i] = 0; slot_key[i] = 0; slot_val[i] = 0;
    end
    for (int i = 0; i < NODES; i++) begin
      min_leaf[i] = 0; min_key[i] = 0; min_val[i] = 0;
    end
    st_cnt = 0; heap_cnt = 0; errors = 0;
  endfunction

  function bit push_stash(bit [10:0] lf, bit [31:0] k, bit [31:0] v);
    if (st_cnt >= STASH) begin
      dropped = 1;
      return 0;
    end
    st_leaf[st_cnt] = lf; st_key[st_cnt] = k; st_val[st_cnt] = v;
    st_cnt++;
    return 1;
  endfunction

  // pull a path into the stash, optionally leaving out one matching block
  function void load_path(int unsigned lf, bit skip, bit [31:0] k, bit [31:0] v);
    int unsigned node;
    int unsigned idx;
    bit gone;
    node = CAP - 1 + lf;
    gone = 0;
    while (node > 0) begin
      for (int s = 0; s < BKT; s++) begin
        idx = (node - 1) * BKT + s;
        if (skip && !gone && slot_leaf[idx] == lf && slot_key[idx] == k &&
            slot_val[idx] == v)
          gone = 1;
        else if (slot_leaf[idx] != 0)
          void'(push_stash(slot_leaf[idx], slot_key[idx], slot_val[idx]));
      end
      node >>= 1;
    end
  endfunction

  function void write_path(int unsigned lf);
    bit taken[STASH];
    int unsigned node, lvl, b, n, idx, sib, w;
    bit [10:0] c_leaf, m_leaf;
    bit [31:0] c_key, c_val, m_key, m_val;
    for (int j = 0; j < STASH; j++) taken[j] = 0;
    node = CAP - 1 + lf;
    lvl = 0;
    c_leaf = 0; c_key = 0; c_val = 0;
    while (node > 0) begin
      b = node - 1;
      n = 0;
      m_leaf = c_leaf; m_key = c_key; m_val = c_val;
      for (int j = 0; j < st_cnt && n < BKT; j++) begin
        if (!taken[j] && ((CAP - 1 + st_leaf[j]) >> lvl) == node) begin
          idx = b * BKT + n;
          slot_leaf[idx] = st_leaf[j]; slot_key[idx] = st_key[j];
          slot_val[idx] = st_val[j];
          taken[j] = 1;
          n++;
        end
      end
      for (; n < BKT; n++) begin
        idx = b * BKT + n;
        slot_leaf[idx] = 0; slot_key[idx] = 0; slot_val[idx] = 0;
      end
      for (int s = 0; s < BKT; s++) begin
        idx = b * BKT + s;
        if (slot_leaf[idx] != 0 && (m_leaf == 0 || slot_key[idx] < m_key)) begin
          m_leaf = slot_leaf[idx]; m_key = slot_key[idx]; m_val = slot_val[idx];
        end
      end
      min_leaf[b] = m_leaf; min_key[b] = m_key; min_val[b] = m_val;
      c_leaf = m_leaf; c_key = m_key; c_val = m_val;
      if (b != 0) begin
        sib = b[0] ? b + 1 : b - 1;
        if (min_leaf[sib] != 0 && (m_leaf == 0 || min_key[sib] < m_key)) begin
          c_leaf = min_leaf[sib]; c_key = min_key[sib]; c_val = min_val[sib];
        end
      end
      node >>= 1;
      lvl++;
    end
    w = 0;
    for (int j = 0; j < st_cnt; j++) begin
      if (!taken[j]) begin
        st_leaf[w] = st_leaf[j]; st_key[w] = st_key[j]; st_val[w] = st_val[j];
        w++;
      end
    end
    st_cnt = w;
  endfunction

  function void refresh_pair(int unsigned ra, int unsigned rb);
    int unsigned p1, p2;
    p1 = 1 + (ra >> 1);
    p2 = 1 + ((rb >> 1) | (CAP >> 1));
    load_path(p1, 0, 0, 0); write_path(p1);
    load_path(p2, 0, 0, 0); write_path(p2);
  endfunction

  // note an accepted input item and queue its expected result
  function void note_input(pomh_pkg::pomh_in_t it);
    pomh_pkg::pomh_out_t r;
    bit [10:0] rl;
    bit [31:0] rk, rv;
    int unsigned half, p2;
    rl = min_leaf[0]; rk = min_key[0]; rv = min_val[0];
    r = '0;
    dropped = 0;
    case (it.op)
      pomh_pkg::OP_FIND, pomh_pkg::OP_PAD_FIND: begin
        if (rl != 0) begin
          r.min_valid = 1; r.min_key = rk; r.min_value = rv;
        end
        if (it.op == pomh_pkg::OP_PAD_FIND) refresh_pair(it.rand_a, it.rand_b);
      end
      pomh_pkg::OP_INSERT: begin
        if (push_stash(it.rand_a + 1, it.key, it.value) && heap_cnt < 2047)
          heap_cnt++;
        refresh_pair(it.rand_b, it.rand_c);
      end
      default: begin
        if (rl == 0) refresh_pair(it.rand_a, it.rand_b);
        else begin
          half = CAP >> 1;
          p2 = (((half & (rl - 1)) ^ half) | (it.rand_b >> 1)) + 1;
          r.min_valid = 1; r.min_key = rk; r.min_value = rv;
          load_path(rl, 1, rk, rv); write_path(rl);
          load_path(p2, 0, 0, 0); write_path(p2);
          if (heap_cnt > 0) heap_cnt--;
        end
      end
    endcase
    r.stash_overflow = dropped;
    r.element_count = heap_cnt[10:0];
    pending_results.insert(pending_results.size(), r);
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  task check_result(pomh_pkg::pomh_out_t got);
    pomh_pkg::pomh_out_t want;
    if (pending_results.size() == 0) begin
      report("unexpected result", longint'(got.min_key), 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.min_valid !== want.min_valid) report("min_valid", got.min_valid, want.min_valid);
    if (got.min_key !== want.min_key) report("min_key", got.min_key, want.min_key);
    if (got.min_value !== want.min_value) report("min_value", got.min_value, want.min_value);
    if (got.stash_overflow !== want.stash_overflow)
      report("stash_overflow", got.stash_overflow, want.stash_overflow);
    if (got.element_count !== want.element_count)
      report("element_count", got.element_count, want.element_count);
  endtask
endclass

module path_oblivious_min_heap_top_test;
  import pomh_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  pomh_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  pomh_out_t out_data_o;

  heap_scoreboard heap_sb;
  int  idle_pct;       // sender idle chance
  int  stall_pct;      // receiver stall chance
  bit  hold_off;       // long receiver hold-off in progress
  longint cycle_cnt;

  path_oblivious_min_heap_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall, or held high during a hold-off; results checked
  // at the edge where they are accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) heap_sb.check_result(out_data_o);
      out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  // generous limit on the total run time, stalls included
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 12_000_000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // offer one item until accepted, with random idle cycles first
  task automatic send_item(pomh_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    heap_sb.note_input(it);
    in_valid_i <= 1'b0;
  endtask

  function automatic pomh_in_t rand_item(int ins_pct, int ext_pct);
    pomh_in_t it;
    int p;
    p = $urandom_range(99);
    it.key    = $urandom;
    // narrow keys often so that ties show up
    if ($urandom_range(3) == 0) it.key = $urandom_range(15);
    it.value  = $urandom;
    it.rand_a = $urandom_range(1023);
    it.rand_b = $urandom_range(1023);
    it.rand_c = $urandom_range(1023);
    if (p < ins_pct) it.op = OP_INSERT;
    else if (p < ins_pct + ext_pct) it.op = OP_EXTRACT;
    else if (p[0]) it.op = OP_FIND;
    else it.op = OP_PAD_FIND;
    return it;
  endfunction

  function automatic pomh_in_t make_item(logic [1:0] op, logic [31:0] k, logic [31:0] v,
                                         logic [9:0] a, logic [9:0] b, logic [9:0] c);
    pomh_in_t it;
    it.op = op; it.key = k; it.value = v;
    it.rand_a = a; it.rand_b = b; it.rand_c = c;
    return it;
  endfunction

  task automatic run_phase(int n, int idle, int stall, int ins_pct, int ext_pct);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_item(rand_item(ins_pct, ext_pct));
  endtask

  initial begin
    heap_sb    = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_off   = 0;
    cycle_cnt  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty heap, field extremes, same leaf, duplicate keys
    send_item(make_item(OP_FIND, '0, '0, '0, '0, '0));
    send_item(make_item(OP_PAD_FIND, '1, '1, '1, '1, '1));
    send_item(make_item(OP_EXTRACT, '0, '0, 10'd1023, 10'd0, '0));
    send_item(make_item(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff, 10'd1023, 10'd1023, 10'd1023));
    send_item(make_item(OP_INSERT, 32'h0, 32'h0, 10'd0, 10'd0, 10'd0));
    send_item(make_item(OP_INSERT, 32'h5, 32'haaaa_5555, 10'd7, 10'd0, 10'd1));
    send_item(make_item(OP_INSERT, 32'h5, 32'haaaa_5555, 10'd7, 10'd2, 10'd3));
    send_item(make_item(OP_INSERT, 32'h5, 32'h5555_aaaa, 10'd7, 10'd4, 10'd5));
    send_item(make_item(OP_FIND, '0, '0, '0, '0, '0));
    send_item(make_item(OP_PAD_FIND, '0, '0, 10'd512, 10'd511, '0));
    repeat (4) send_item(make_item(OP_EXTRACT, '0, '0, '0, 10'd1023, '0));
    send_item(make_item(OP_FIND, '0, '0, '0, '0, '0));
    repeat (3) send_item(make_item(OP_EXTRACT, '0, '0, '0, '0, '0));
    // many blocks on one leaf: buckets on that path fill, stash grows
    repeat (50) send_item(make_item(OP_INSERT, $urandom, $urandom, 10'd3, 10'd6, 10'd6));

    // random phases: build up, churn, drain
    run_phase(300, 0,  0,  70, 20);
    run_phase(300, 68, 0,  45, 45);
    run_phase(300, 0,  68, 50, 40);
    run_phase(200, 6,  6,  45, 45);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (8000) @(posedge clk_i);
        hold_off = 0;
      end
      run_phase(20, 0, 0, 50, 40);
    join

    run_phase(400, 6, 6, 25, 65);
    stall_pct = 0;

    while (heap_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (heap_sb.errors == 0 && heap_sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
